// File: rtl/vgrt_pkg.sv
// Package: shared types and constants for the voxel ray traversal unit.
`default_nettype none
package vgrt_pkg;
  localparam int AXIS_BITS = 6;
  localparam int MAX_STEPS = 256;
  localparam int GRID_SIDE = 1 << AXIS_BITS;
  localparam int ADDR_W = 3 * AXIS_BITS;
  localparam int STEP_W = 9;
  localparam int T_W = 48;
  localparam int Q_W = 40;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  // rounded t at or above this gives a quotient past DIST_MAX
  localparam logic [T_W-1:0] DIST_SAT = T_W'(167772160);
  // ceil(2^35 / 10): exact divide by 10 for operands below 2^32
  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

  localparam logic [1:0] CFG_EXTENT_X = 2'd0;
  localparam logic [1:0] CFG_EXTENT_Y = 2'd1;
  localparam logic [1:0] CFG_EXTENT_Z = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_PICK, ST_READ, ST_TEST, ST_DIST, ST_DONE
  } state_t;

  typedef struct packed {
    logic             we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// File: rtl/voxel_grid_ray_traversal_unit.sv
// Voxel ray traversal unit: cast/write items, per-item result strobe.
// A write does not leave idle, so writes can follow back to back. A cast runs one
// shared restoring divider for tmax and the step of each nonzero heading
// component, skipping zero components, then a pick, a grid read and a test per
// voxel step for up to 257 steps, and a distance state on a hit; an all-zero
// heading reports a miss without stepping. Results come out on out_valid for one
// cycle; the receiver cannot stall. The grid memory is not cleared after reset.
`default_nettype none
module voxel_grid_ray_traversal_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic [5:0]         in_cell_x,
  input  wire logic [5:0]         in_cell_y,
  input  wire logic [5:0]         in_cell_z,
  input  wire logic [7:0]         in_cell_value,
  input  wire logic signed [23:0] in_origin_x,
  input  wire logic signed [23:0] in_origin_y,
  input  wire logic signed [23:0] in_origin_z,
  input  wire logic signed [19:0] in_heading_x,
  input  wire logic signed [19:0] in_heading_y,
  input  wire logic signed [19:0] in_heading_z,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [23:0]             out_distance,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [6:0]         cfg_data
);
  import vgrt_pkg::*;
  logic [6:0] ext_x_r, ext_y_r, ext_z_r;
  logic [6:0] lim_x, lim_y, lim_z;
  mem_req_t req;
  logic [7:0] rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r <= 7'd64;
      ext_y_r <= 7'd64;
      ext_z_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXTENT_X: ext_x_r <= cfg_data;
        CFG_EXTENT_Y: ext_y_r <= cfg_data;
        CFG_EXTENT_Z: ext_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lim_x = (ext_x_r > 7'(GRID_SIDE)) ? 7'(GRID_SIDE) : ext_x_r;
  assign lim_y = (ext_y_r > 7'(GRID_SIDE)) ? 7'(GRID_SIDE) : ext_y_r;
  assign lim_z = (ext_z_r > 7'(GRID_SIDE)) ? 7'(GRID_SIDE) : ext_z_r;

  vgrt_grid_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  vgrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start && !busy), .in_command(in_command),
    .in_cell_x(in_cell_x), .in_cell_y(in_cell_y), .in_cell_z(in_cell_z),
    .in_cell_value(in_cell_value), .in_origin_x(in_origin_x),
    .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_heading_x(in_heading_x), .in_heading_y(in_heading_y),
    .in_heading_z(in_heading_z), .lim_x(lim_x), .lim_y(lim_y), .lim_z(lim_z),
    .rdata(rdata), .req(req), .busy(busy), .out_valid(out_valid),
    .out_hit(out_hit), .out_distance(out_distance)
  );
endmodule
`default_nettype wire

// File: rtl/vgrt_grid_mem.sv
// Voxel occupancy memory: one write port, one registered read port.
`default_nettype none
module vgrt_grid_mem (
  input  wire logic              clk,
  input  wire vgrt_pkg::mem_req_t req,
  output logic [7:0]             rdata
);
  import vgrt_pkg::*;
  logic [7:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

// File: rtl/vgrt_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned.
`default_nettype none
module vgrt_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [vgrt_pkg::Q_W-1:0]   dividend,
  input  wire logic [vgrt_pkg::Q_W-1:0]   divisor,
  output logic                            done,
  output logic [vgrt_pkg::Q_W-1:0]        quotient
);
  import vgrt_pkg::*;
  logic [Q_W-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [Q_W:0] rem_r, rem_nxt, trial;
  logic [5:0] cnt_r, cnt_nxt;
  logic run_r, run_nxt;

  always_comb begin
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial = '0;
    done = 1'b0;
    if (start) begin
      q_nxt = dividend;
      d_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = 6'(Q_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      trial = {rem_r[Q_W-1:0], q_r[Q_W-1]};
      q_nxt = {q_r[Q_W-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign quotient = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/vgrt_ctrl.sv
// Traversal sequencer: grid writes, setup divisions, DDA stepping, grid reads and distance.
`default_nettype none
module vgrt_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        in_command,
  input  wire logic [5:0]                  in_cell_x,
  input  wire logic [5:0]                  in_cell_y,
  input  wire logic [5:0]                  in_cell_z,
  input  wire logic [7:0]                  in_cell_value,
  input  wire logic signed [23:0]          in_origin_x,
  input  wire logic signed [23:0]          in_origin_y,
  input  wire logic signed [23:0]          in_origin_z,
  input  wire logic signed [19:0]          in_heading_x,
  input  wire logic signed [19:0]          in_heading_y,
  input  wire logic signed [19:0]          in_heading_z,
  input  wire logic [6:0]                  lim_x,
  input  wire logic [6:0]                  lim_y,
  input  wire logic [6:0]                  lim_z,
  input  wire logic [7:0]                  rdata,
  output vgrt_pkg::mem_req_t               req,
  output logic                             busy,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [23:0]                      out_distance
);
  import vgrt_pkg::*;

  state_t state_r, state_nxt;
  logic signed [8:0] vox_r [3];
  logic signed [8:0] vox_nxt [3];
  logic [T_W-1:0] tmax_r [3];
  logic [T_W-1:0] tmax_nxt [3];
  logic [T_W-1:0] tdel_r [3];
  logic [T_W-1:0] tdel_nxt [3];
  logic [2:0] live_r, neg_r, sel_r, sel_nxt;
  logic [15:0] frac_r [3];
  logic signed [19:0] hd_r [3];
  logic [T_W-1:0] tmin_r, tmin_nxt;
  logic [2:0] div_idx_r, div_idx_nxt;
  logic [STEP_W-1:0] n_r, n_nxt;
  logic valid_r, valid_nxt, hit_r, hit_nxt;
  logic [23:0] dist_r, dist_nxt;
  logic signed [23:0] org [3];
  logic signed [19:0] hd [3];
  logic div_start, div_done;
  logic [Q_W-1:0] div_a, div_b, div_q;
  logic [T_W-1:0] tmin_c;
  logic [T_W-1:0] rnd_t;
  logic [59:0] prod;
  logic outside;
  logic signed [8:0] sv [3];

  assign org[0] = in_origin_x; assign org[1] = in_origin_y; assign org[2] = in_origin_z;
  assign hd[0] = in_heading_x; assign hd[1] = in_heading_y; assign hd[2] = in_heading_z;

  vgrt_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  // divider slots: 0..2 tmax per axis, 3..5 tdelta per axis
  logic [1:0] ax;
  logic [19:0] mag;
  logic [16:0] num;
  always_comb begin
    ax = (div_idx_r >= 3'd3) ? 2'(div_idx_r - 3'd3) : div_idx_r[1:0];
    if (ax == 2'd3) ax = 2'd0;
    mag = hd_r[ax][19] ? 20'(-hd_r[ax]) : hd_r[ax];
    num = hd_r[ax][19] ? {1'b0, frac_r[ax]} : 17'h10000 - {1'b0, frac_r[ax]};
  end

  always_comb begin
    tmin_c = '1;
    for (int a = 0; a < 3; a++)
      if (live_r[a] && tmax_r[a] < tmin_c) tmin_c = tmax_r[a];
  end

  // distance = (t + 5) / 10 by reciprocal multiply, saturated
  always_comb begin
    rnd_t = tmin_r + T_W'(5);
    prod = 60'(rnd_t[27:0]) * 60'(RECIP_10);
  end

  always_comb begin
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sv[a] = vox_r[a];
      if (a == 0 && (sv[a] < 0 || sv[a] >= $signed({2'b0, lim_x}))) outside = 1'b1;
      if (a == 1 && (sv[a] < 0 || sv[a] >= $signed({2'b0, lim_y}))) outside = 1'b1;
      if (a == 2 && (sv[a] < 0 || sv[a] >= $signed({2'b0, lim_z}))) outside = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    vox_nxt = vox_r;
    tmax_nxt = tmax_r;
    tdel_nxt = tdel_r;
    sel_nxt = sel_r;
    tmin_nxt = tmin_r;
    div_idx_nxt = div_idx_r;
    n_nxt = n_r;
    valid_nxt = 1'b0;
    hit_nxt = hit_r;
    dist_nxt = dist_r;
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    req = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          hit_nxt = 1'b0;
          dist_nxt = '0;
          if (in_command == CMD_WRITE) begin
            req.we = 1'b1;
            req.waddr = {in_cell_z, in_cell_y, in_cell_x};
            req.wdata = in_cell_value;
            valid_nxt = 1'b1;
          end else begin
            for (int a = 0; a < 3; a++) vox_nxt[a] = 9'(org[a] >>> 16);
            div_idx_nxt = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // zero heading axes skip their division
        if (div_idx_r < 3'd6 && !live_r[ax]) begin
          if (div_idx_r == 3'd5) begin
            n_nxt = '0;
            state_nxt = (live_r == '0) ? ST_DONE : ST_PICK;
            valid_nxt = (live_r == '0);
          end
          div_idx_nxt = div_idx_r + 3'd1;
        end else begin
          div_start = 1'b1;
          div_a = (div_idx_r < 3'd3) ? Q_W'({num, 16'h0}) : Q_W'(64'h1_0000_0000);
          div_b = Q_W'(mag);
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (div_done) begin
          if (div_idx_r < 3'd3) tmax_nxt[ax] = T_W'(div_q);
          else tdel_nxt[ax] = T_W'(div_q);
          if (div_idx_r == 3'd5) begin
            n_nxt = '0;
            state_nxt = ST_PICK;
          end else begin
            state_nxt = ST_DIV;
          end
          div_idx_nxt = div_idx_r + 3'd1;
        end
      end
      ST_PICK: begin
        tmin_nxt = tmin_c;
        for (int a = 0; a < 3; a++) begin
          sel_nxt[a] = live_r[a] && tmax_r[a] == tmin_c;
          if (sel_nxt[a]) vox_nxt[a] = neg_r[a] ? vox_r[a] - 9'sd1 : vox_r[a] + 9'sd1;
        end
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (outside) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          req.re = 1'b1;
          req.raddr = {vox_r[2][5:0], vox_r[1][5:0], vox_r[0][5:0]};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (div_idx_r == 3'd7) begin
          // start voxel never tested: all-zero heading lands here
          state_nxt = ST_IDLE;
        end else if (rdata != 8'd0) begin
          state_nxt = ST_DIST;
        end else begin
          for (int a = 0; a < 3; a++)
            if (sel_r[a]) tmax_nxt[a] = tmax_r[a] + tdel_r[a];
          if (n_r == STEP_W'(MAX_STEPS)) begin
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            n_nxt = n_r + STEP_W'(1);
            state_nxt = ST_PICK;
          end
        end
      end
      ST_DIST: begin
        hit_nxt = 1'b1;
        dist_nxt = (rnd_t >= DIST_SAT) ? DIST_MAX : prod[58:35];
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_DIV && div_idx_r == 3'd5 && !live_r[ax] && live_r == '0)
      div_idx_nxt = 3'd7;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= (state_r == ST_DONE && div_idx_r == 3'd7) ? ST_IDLE : state_nxt;
      valid_r <= valid_nxt;
    end
    if (state_r == ST_IDLE && start) begin
      for (int a = 0; a < 3; a++) begin
        live_r[a] <= (hd[a] != 20'sd0);
        neg_r[a] <= hd[a][19];
        frac_r[a] <= org[a][15:0];
        hd_r[a] <= hd[a];
        tmax_r[a] <= '0;
        tdel_r[a] <= '0;
      end
    end else begin
      tmax_r <= tmax_nxt;
      tdel_r <= tdel_nxt;
    end
    vox_r <= vox_nxt;
    sel_r <= sel_nxt;
    tmin_r <= tmin_nxt;
    div_idx_r <= div_idx_nxt;
    n_r <= n_nxt;
    hit_r <= hit_nxt;
    dist_r <= dist_nxt;
  end

  assign out_valid = valid_r;
  assign out_hit = hit_r;
  assign out_distance = dist_r;
endmodule
`default_nettype wire

// File: rtl/vgrt_checker.sv
// Port-level checker for the voxel ray traversal unit, bound to the top level.
`default_nettype none
module vgrt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_command,
  input wire logic        out_valid,
  input wire logic        out_hit,
  input wire logic [23:0] out_distance
);
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == 24'd0) else $error("miss with distance");
  a_write_one: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_command |=> out_valid && !out_hit) else $error("write result");
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command |=> busy) else $error("cast not busy");
  a_cast_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command |=> !out_valid) else $error("cast result too early");
endmodule

bind voxel_grid_ray_traversal_unit vgrt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_command(in_command),
  .out_valid(out_valid), .out_hit(out_hit), .out_distance(out_distance)
);
`default_nettype wire
